/* rtl/core/ppmc_pkg.sv */
package ppmc_pkg;

  localparam int MOD_BITS   = 32;
  localparam int CNT_BITS   = 32;

  localparam int BEAM_W     = 5;
  localparam int MOD_W      = 32;
  localparam int SEV_W      = 2;
  localparam int AVG_W      = 16;
  localparam int TOTAL_W    = 32;
  localparam int DELAY_W    = 3;
  localparam int MASK_W     = 64;
  localparam int CFG_DATA_W = 64;
  localparam int CFG_IDX_W  = 3;
  localparam int NUM_MODS   = 4;

  localparam logic [DELAY_W-1:0] DELAY_SAT        = 3'd4;
  localparam logic [DELAY_W-1:0] DELAY_DONE_AFTER = 3'd3;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_BEAM_CODE    = 3'd0,
    CFG_AVG_TARGET   = 3'd1,
    CFG_TOTAL_TARGET = 3'd2,
    CFG_MEAS_LIMIT   = 3'd3,
    CFG_MASKS2       = 3'd4,
    CFG_MASKS3       = 3'd5,
    CFG_MASKS4       = 3'd6,
    CFG_MASKS5       = 3'd7
  } cfg_idx_e;

  // masks[k]: upper half inclusion, lower half exclusion, for modifier k+2
  typedef struct packed {
    logic [BEAM_W-1:0]                 beam_code;
    logic [AVG_W-1:0]                  avg_target;
    logic [TOTAL_W-1:0]                total_target;
    logic                              endless;
    logic [NUM_MODS-1:0][MASK_W-1:0]   masks;
  } cfg_t;

  typedef struct packed {
    logic [BEAM_W-1:0]                 beam_code;
    logic [NUM_MODS-1:0][MOD_W-1:0]    modifier;
    logic [SEV_W-1:0]                  severity;
    logic                              clear_run;
  } pulse_t;

  typedef struct packed {
    logic               pattern_hit;
    logic               step_status;
    logic               average_done;
    logic [AVG_W-1:0]   average_count;
    logic [TOTAL_W-1:0] measure_count;
    logic [DELAY_W-1:0] finish_delay;
    logic               run_done;
  } result_t;

endpackage

/* rtl/core/ppmc_pulse_if.sv */
interface ppmc_pulse_if;
  import ppmc_pkg::*;

  logic               valid;
  logic               ready;
  logic [BEAM_W-1:0]  beam_code;
  logic [MOD_W-1:0]   modifier_two;
  logic [MOD_W-1:0]   modifier_three;
  logic [MOD_W-1:0]   modifier_four;
  logic [MOD_W-1:0]   modifier_five;
  logic [SEV_W-1:0]   data_severity;
  logic               clear_run;

  modport source (
    output valid, beam_code, modifier_two, modifier_three, modifier_four,
           modifier_five, data_severity, clear_run,
    input  ready
  );

  modport sink (
    input  valid, beam_code, modifier_two, modifier_three, modifier_four,
           modifier_five, data_severity, clear_run,
    output ready
  );
endinterface

/* rtl/core/ppmc_result_if.sv */
interface ppmc_result_if;
  import ppmc_pkg::*;

  logic               valid;
  logic               ready;
  logic               pattern_hit;
  logic               step_status;
  logic               average_done;
  logic [AVG_W-1:0]   average_count;
  logic [TOTAL_W-1:0] measure_count;
  logic [DELAY_W-1:0] finish_delay;
  logic               run_done;

  modport source (
    output valid, pattern_hit, step_status, average_done, average_count,
           measure_count, finish_delay, run_done,
    input  ready
  );

  modport sink (
    input  valid, pattern_hit, step_status, average_done, average_count,
           measure_count, finish_delay, run_done,
    output ready
  );
endinterface

/* rtl/core/ppmc_cfg_regs.sv */
module ppmc_cfg_regs (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           cfg_we_i,
  input  ppmc_pkg::cfg_idx_e             cfg_idx_i,
  input  logic [ppmc_pkg::CFG_DATA_W-1:0] cfg_data_i,
  output ppmc_pkg::cfg_t                 cfg_o
);
  import ppmc_pkg::*;

  cfg_t cfg_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.beam_code    <= '0;
      cfg_q.avg_target   <= AVG_W'(1);
      cfg_q.total_target <= '0;
      cfg_q.endless      <= 1'b1;
      cfg_q.masks        <= '0;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        CFG_BEAM_CODE:    cfg_q.beam_code    <= cfg_data_i[BEAM_W-1:0];
        CFG_AVG_TARGET:   cfg_q.avg_target   <= cfg_data_i[AVG_W-1:0];
        CFG_TOTAL_TARGET: cfg_q.total_target <= cfg_data_i[TOTAL_W-1:0];
        // only the sign of the limit matters
        CFG_MEAS_LIMIT:   cfg_q.endless      <= cfg_data_i[16];
        CFG_MASKS2:       cfg_q.masks[0]     <= cfg_data_i[MASK_W-1:0];
        CFG_MASKS3:       cfg_q.masks[1]     <= cfg_data_i[MASK_W-1:0];
        CFG_MASKS4:       cfg_q.masks[2]     <= cfg_data_i[MASK_W-1:0];
        CFG_MASKS5:       cfg_q.masks[3]     <= cfg_data_i[MASK_W-1:0];
        default:          cfg_q              <= cfg_q;
      endcase
    end
  end

  assign cfg_o = cfg_q;

endmodule

/* rtl/core/ppmc_match.sv */
module ppmc_match (
  input  ppmc_pkg::cfg_t   cfg_i,
  input  ppmc_pkg::pulse_t pulse_i,
  output logic             match_o
);
  import ppmc_pkg::*;

  logic [NUM_MODS-1:0] word_ok;

  always_comb begin
    logic [MOD_BITS-1:0] w;
    logic [MOD_BITS-1:0] inc;
    logic [MOD_BITS-1:0] exc;
    for (int k = 0; k < NUM_MODS; k++) begin
      w   = pulse_i.modifier[k][MOD_BITS-1:0];
      inc = cfg_i.masks[k][32 +: MOD_BITS];
      exc = cfg_i.masks[k][0 +: MOD_BITS];
      word_ok[k] = ((w & inc) == inc) && ((w & exc) == '0);
    end
  end

  assign match_o = (pulse_i.beam_code == cfg_i.beam_code) && (&word_ok);

endmodule

/* rtl/core/ppmc_track.sv */
module ppmc_track (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              step_i,
  input  ppmc_pkg::cfg_t    cfg_i,
  input  ppmc_pkg::pulse_t  pulse_i,
  input  logic              match_i,
  output ppmc_pkg::result_t res_o
);
  import ppmc_pkg::*;

  logic [DELAY_W-1:0]  delay_q,    delay_d;
  logic [CNT_BITS-1:0] total_q,    total_d;
  logic [AVG_W-1:0]    avg_q,      avg_d;
  logic                avg_done_q, avg_done_d;
  logic                run_done_q, run_done_d;

  logic                hit;
  logic                status;

  always_comb begin
    logic [DELAY_W-1:0]  delay_c;
    logic [CNT_BITS-1:0] total_c;
    logic                run_done_c;
    logic [AVG_W:0]      avg_inc;

    delay_c    = pulse_i.clear_run ? '0   : delay_q;
    total_c    = pulse_i.clear_run ? '0   : total_q;
    run_done_c = pulse_i.clear_run ? 1'b0 : run_done_q;

    delay_d    = delay_c;
    run_done_d = run_done_c;
    if ((TOTAL_W'(total_c) >= cfg_i.total_target) && !cfg_i.endless) begin
      if (delay_c < DELAY_SAT) begin
        delay_d = delay_c + DELAY_W'(1);
      end
      if (delay_d > DELAY_DONE_AFTER) begin
        run_done_d = 1'b1;
      end
    end

    // pulses are only examined while no finish delay runs
    status     = (delay_d == '0) && (pulse_i.severity != '0);
    hit        = (delay_d == '0) && (pulse_i.severity == '0) && match_i;

    total_d    = total_c;
    avg_d      = avg_q;
    avg_done_d = avg_done_q;
    avg_inc    = {1'b0, avg_q} + (AVG_W+1)'(1);
    if (hit) begin
      if (total_c != '1) begin
        total_d = total_c + CNT_BITS'(1);
      end
      if (avg_inc >= {1'b0, cfg_i.avg_target}) begin
        avg_done_d = 1'b1;
        avg_d      = '0;
      end else begin
        avg_done_d = 1'b0;
        avg_d      = avg_inc[AVG_W-1:0];
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      delay_q    <= '0;
      total_q    <= '0;
      avg_q      <= '0;
      avg_done_q <= 1'b0;
      run_done_q <= 1'b0;
    end else if (step_i) begin
      delay_q    <= delay_d;
      total_q    <= total_d;
      avg_q      <= avg_d;
      avg_done_q <= avg_done_d;
      run_done_q <= run_done_d;
    end
  end

  always_comb begin
    res_o.pattern_hit   = hit;
    res_o.step_status   = status;
    res_o.average_done  = avg_done_d;
    res_o.average_count = avg_d;
    res_o.measure_count = TOTAL_W'(total_d);
    res_o.finish_delay  = delay_d;
    res_o.run_done      = run_done_d;
  end

endmodule

/* rtl/core/pulse_pattern_match_counter_core.sv */
// channel   | dir | handshake     | word
// ----------+-----+---------------+--------------------------------------------
// pulse_i   | in  | valid / ready | beam code, modifiers 2..5, severity, clear
// result_o  | out | valid / ready | hit, status, avg done/count, count, delay, done
// cfg       | in  | cfg_we_i      | cfg_idx_i selects register, cfg_data_i value
//
// Two register stages: input word register, then match and counter update into
// the result register. One word per cycle is sustained while result_o is ready.
// Counter state updates when a word moves from the input to the result register.
// A stalled result holds both stages; ready back to pulse_i stays high while a
// slot frees up that cycle. Reset clears valid flags and counters, presets cfg.
module pulse_pattern_match_counter_core (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  ppmc_pulse_if.sink                      pulse_i,
  ppmc_result_if.source                   result_o,
  input  logic                            cfg_we_i,
  input  ppmc_pkg::cfg_idx_e              cfg_idx_i,
  input  logic [ppmc_pkg::CFG_DATA_W-1:0] cfg_data_i
);
  import ppmc_pkg::*;

  cfg_t    cfg;
  pulse_t  pulse_q;
  logic    in_valid_q;
  result_t res_d, res_q;
  logic    out_valid_q;
  logic    advance;
  logic    step;
  logic    in_ready;
  logic    match;

  ppmc_cfg_regs u_cfg (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i),
    .cfg_o      (cfg)
  );

  assign advance = !out_valid_q || result_o.ready;
  assign step    = in_valid_q && advance;
  assign in_ready = !in_valid_q || advance;
  assign pulse_i.ready = in_ready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (in_ready) begin
      in_valid_q <= pulse_i.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (pulse_i.valid && in_ready) begin
      pulse_q.beam_code   <= pulse_i.beam_code;
      pulse_q.modifier[0] <= pulse_i.modifier_two;
      pulse_q.modifier[1] <= pulse_i.modifier_three;
      pulse_q.modifier[2] <= pulse_i.modifier_four;
      pulse_q.modifier[3] <= pulse_i.modifier_five;
      pulse_q.severity    <= pulse_i.data_severity;
      pulse_q.clear_run   <= pulse_i.clear_run;
    end
  end

  ppmc_match u_match (
    .cfg_i   (cfg),
    .pulse_i (pulse_q),
    .match_o (match)
  );

  ppmc_track u_track (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .step_i  (step),
    .cfg_i   (cfg),
    .pulse_i (pulse_q),
    .match_i (match),
    .res_o   (res_d)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (advance) begin
      out_valid_q <= in_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (step) begin
      res_q <= res_d;
    end
  end

  assign result_o.valid         = out_valid_q;
  assign result_o.pattern_hit   = res_q.pattern_hit;
  assign result_o.step_status   = res_q.step_status;
  assign result_o.average_done  = res_q.average_done;
  assign result_o.average_count = res_q.average_count;
  assign result_o.measure_count = res_q.measure_count;
  assign result_o.finish_delay  = res_q.finish_delay;
  assign result_o.run_done      = res_q.run_done;

endmodule

/* verif/pulse_pattern_match_counter_core_tb.sv */
`timescale 1ns / 1ps

module pulse_pattern_match_counter_core_tb;
  import ppmc_pkg::*;

  localparam int RANDOM_PULSES = 600;
  localparam int STALL_LIMIT   = 2000;
  localparam int LONG_HOLD     = 80;
  localparam int SETTLE        = 4;
  localparam int NUM_REGS      = 8;
  localparam int MAX_REPORTS   = 10;

  class pulse_scoreboard;
    logic [BEAM_W-1:0]   want_code;
    logic [AVG_W-1:0]    avg_target;
    logic [TOTAL_W-1:0]  total_target;
    logic [16:0]         meas_limit;
    logic [MASK_W-1:0]   masks [NUM_MODS];
    logic [DELAY_W-1:0]  delay_cnt;
    logic [CNT_BITS-1:0] match_cnt;
    logic [AVG_W:0]      avg_prog;
    logic                avg_done;
    logic                run_done;
    result_t             expected_q [$];
    int                  mismatches;

    function new();
      want_code    = '0;
      avg_target   = 1;
      total_target = '0;
      meas_limit   = '1;
      foreach (masks[k]) masks[k] = '0;
      delay_cnt    = '0;
      match_cnt    = '0;
      avg_prog     = '0;
      avg_done     = 1'b0;
      run_done     = 1'b0;
      mismatches   = 0;
    endfunction

    function void write_reg(cfg_idx_e idx, logic [CFG_DATA_W-1:0] d);
      case (idx)
        CFG_BEAM_CODE:    want_code    = d[BEAM_W-1:0];
        CFG_AVG_TARGET:   avg_target   = d[AVG_W-1:0];
        CFG_TOTAL_TARGET: total_target = d[TOTAL_W-1:0];
        CFG_MEAS_LIMIT:   meas_limit   = d[16:0];
        CFG_MASKS2:       masks[0]     = d;
        CFG_MASKS3:       masks[1]     = d;
        CFG_MASKS4:       masks[2]     = d;
        CFG_MASKS5:       masks[3]     = d;
        default: ;
      endcase
    endfunction

    // all inclusion bits present, no exclusion bit present
    function bit word_passes(logic [MOD_W-1:0] w, logic [MASK_W-1:0] m);
      logic [MOD_W-1:0] keep, word, inc, exc;
      keep = {MOD_W{1'b1}} >> (MOD_W - MOD_BITS);
      word = w & keep;
      inc  = m[MASK_W-1:MOD_W] & keep;
      exc  = m[MOD_W-1:0] & keep;
      return ((word & inc) == inc) && ((word & exc) == '0);
    endfunction

    function void note_pulse(pulse_t p);
      result_t r;
      bit      matched;
      r = '0;
      if (p.clear_run) begin
        delay_cnt = '0;
        match_cnt = '0;
        run_done  = 1'b0;
      end
      // bit 16 of the limit is the sign: negative means endless
      if (match_cnt >= total_target && !meas_limit[16]) begin
        if (delay_cnt < DELAY_SAT) delay_cnt++;
        if (delay_cnt > DELAY_DONE_AFTER) run_done = 1'b1;
      end
      if (delay_cnt == '0) begin
        matched = (p.beam_code == want_code);
        for (int k = 0; k < NUM_MODS; k++) begin
          matched &= word_passes(p.modifier[k], masks[k]);
        end
        if (p.severity != '0) begin
          r.step_status = 1'b1;
        end else if (matched) begin
          r.pattern_hit = 1'b1;
          if (match_cnt != '1) match_cnt++;
          avg_prog = avg_prog + 1'b1;
          if (avg_prog >= {1'b0, avg_target}) begin
            avg_done = 1'b1;
            avg_prog = '0;
          end else begin
            avg_done = 1'b0;
          end
        end
      end
      r.average_done  = avg_done;
      r.average_count = avg_prog[AVG_W-1:0];
      r.measure_count = match_cnt;
      r.finish_delay  = delay_cnt;
      r.run_done      = run_done;
      expected_q.push_back(r);
    endfunction

    function void check_result(result_t got);
      result_t want;
      if (expected_q.size() == 0) begin
        mismatches++;
        if (mismatches <= MAX_REPORTS) $display("unexpected result word: %p", got);
        return;
      end
      want = expected_q.pop_front();
      if (got.pattern_hit !== want.pattern_hit || got.step_status !== want.step_status ||
          got.average_done !== want.average_done ||
          got.average_count !== want.average_count ||
          got.measure_count !== want.measure_count ||
          got.finish_delay !== want.finish_delay || got.run_done !== want.run_done) begin
        mismatches++;
        if (mismatches <= MAX_REPORTS) begin
          $display("mismatch: exp hit=%0b st=%0b ad=%0b ac=%0d mc=%0d fd=%0d rd=%0b",
                   want.pattern_hit, want.step_status, want.average_done,
                   want.average_count, want.measure_count, want.finish_delay,
                   want.run_done);
          $display("          got hit=%0b st=%0b ad=%0b ac=%0d mc=%0d fd=%0d rd=%0b",
                   got.pattern_hit, got.step_status, got.average_done,
                   got.average_count, got.measure_count, got.finish_delay,
                   got.run_done);
        end
      end
    endfunction

    function int pending();
      return expected_q.size();
    endfunction
  endclass

  logic                  clk_i;
  logic                  rst_ni;
  logic                  cfg_we_i;
  cfg_idx_e              cfg_idx_i;
  logic [CFG_DATA_W-1:0] cfg_data_i;

  ppmc_pulse_if  pulse_if ();
  ppmc_result_if result_if ();

  pulse_scoreboard       sb;
  logic [CFG_DATA_W-1:0] regs [NUM_REGS];
  bit                    hold_req;
  bit                    tx_steady;
  bit                    rx_steady;
  int                    pulses_sent;
  int                    stall_cycles = 0;

  pulse_pattern_match_counter_core u_dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .pulse_i    (pulse_if),
    .result_o   (result_if),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i)
  );

  initial begin
    clk_i = 1'b0;
    forever #10 clk_i = ~clk_i;
  end

  always @(posedge clk_i) begin
    if ((pulse_if.valid && pulse_if.ready) || (result_if.valid && result_if.ready)) begin
      stall_cycles <= 0;
    end else begin
      stall_cycles <= stall_cycles + 1;
    end
    if (stall_cycles >= STALL_LIMIT) begin
      $display("FAIL");
      $finish;
    end
  end

  // occasionally flips into a stretch of back-to-back words
  function automatic int draw_gap(inout bit steady);
    if ($urandom_range(0, 23) == 0) steady = ~steady;
    return steady ? 0 : $urandom_range(0, 15);
  endfunction

  function automatic pulse_t mk(logic [BEAM_W-1:0] code, logic [MOD_W-1:0] m2,
                                logic [MOD_W-1:0] m3, logic [MOD_W-1:0] m4,
                                logic [MOD_W-1:0] m5, logic [SEV_W-1:0] sev, logic clr);
    pulse_t p;
    p.beam_code   = code;
    p.modifier[0] = m2;
    p.modifier[1] = m3;
    p.modifier[2] = m4;
    p.modifier[3] = m5;
    p.severity    = sev;
    p.clear_run   = clr;
    return p;
  endfunction

  // shaped words mostly satisfy the current definition so the counters move
  function automatic pulse_t make_pulse(bit shaped);
    pulse_t           p;
    logic [MOD_W-1:0] inc, exc;
    p.beam_code = BEAM_W'($urandom_range(0, 31));
    for (int k = 0; k < NUM_MODS; k++) p.modifier[k] = $urandom;
    if (!shaped) begin
      p.severity  = SEV_W'($urandom_range(0, 3));
      p.clear_run = 1'($urandom_range(0, 1));
      return p;
    end
    p.severity  = ($urandom_range(0, 9) == 0) ? SEV_W'($urandom_range(1, 3)) : '0;
    p.clear_run = ($urandom_range(0, (sb.delay_cnt != '0) ? 5 : 24) == 0);
    if ($urandom_range(0, 7) != 0) p.beam_code = sb.want_code;
    for (int k = 0; k < NUM_MODS; k++) begin
      if ($urandom_range(0, 15) != 0) begin
        inc = sb.masks[k][MASK_W-1:MOD_W];
        exc = sb.masks[k][MOD_W-1:0];
        p.modifier[k] = (p.modifier[k] & ~exc) | inc;
      end
    end
    return p;
  endfunction

  function automatic void randomize_regs();
    logic [MOD_W-1:0] inc, exc;
    regs[CFG_BEAM_CODE] = CFG_DATA_W'($urandom_range(0, 31));
    case ($urandom_range(0, 9))
      0:       regs[CFG_AVG_TARGET] = '0;
      1:       regs[CFG_AVG_TARGET] = CFG_DATA_W'(16'hFFFF);
      default: regs[CFG_AVG_TARGET] = CFG_DATA_W'($urandom_range(1, 6));
    endcase
    case ($urandom_range(0, 19))
      0, 1:    regs[CFG_TOTAL_TARGET] = '0;
      2:       regs[CFG_TOTAL_TARGET] = CFG_DATA_W'(32'hFFFF_FFFF);
      default: regs[CFG_TOTAL_TARGET] = CFG_DATA_W'($urandom_range(1, 30));
    endcase
    case ($urandom_range(0, 5))
      0, 1:    regs[CFG_MEAS_LIMIT] = CFG_DATA_W'(17'h1FFFF);
      2:       regs[CFG_MEAS_LIMIT] = '0;
      3:       regs[CFG_MEAS_LIMIT] = CFG_DATA_W'(17'h0FFFF);
      default: regs[CFG_MEAS_LIMIT] = CFG_DATA_W'($urandom_range(1, 65535));
    endcase
    for (int k = 0; k < NUM_MODS; k++) begin
      case ($urandom_range(0, 9))
        0:       begin inc = '0; exc = '0; end
        1:       begin inc = '1; exc = '0; end
        2:       begin inc = '0; exc = '1; end
        default: begin
          inc = $urandom & $urandom & $urandom;
          exc = $urandom & $urandom & $urandom & ~inc;
        end
      endcase
      regs[CFG_MASKS2 + k] = {inc, exc};
    end
  endfunction

  task automatic send_pulse(input pulse_t p);
    int gap;
    gap = draw_gap(tx_steady);
    if (gap > 0) begin
      pulse_if.valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    pulse_if.valid          <= 1'b1;
    pulse_if.beam_code      <= p.beam_code;
    pulse_if.modifier_two   <= p.modifier[0];
    pulse_if.modifier_three <= p.modifier[1];
    pulse_if.modifier_four  <= p.modifier[2];
    pulse_if.modifier_five  <= p.modifier[3];
    pulse_if.data_severity  <= p.severity;
    pulse_if.clear_run      <= p.clear_run;
    @(posedge clk_i);
    while (!pulse_if.ready) @(posedge clk_i);
    sb.note_pulse(p);
  endtask

  // registers only change once the pipeline has drained
  task automatic apply_config();
    pulse_if.valid <= 1'b0;
    while (sb.pending() != 0) @(posedge clk_i);
    repeat (SETTLE) @(posedge clk_i);
    for (int i = 0; i < NUM_REGS; i++) begin
      cfg_we_i   <= 1'b1;
      cfg_idx_i  <= cfg_idx_e'(i);
      cfg_data_i <= regs[i];
      @(posedge clk_i);
      sb.write_reg(cfg_idx_e'(i), regs[i]);
    end
    cfg_we_i <= 1'b0;
  endtask

  task automatic run_directed();
    // reset defaults: beam code 0, empty masks, endless
    send_pulse(mk(0, '0, '0, '0, '0, 0, 0));
    send_pulse(mk(31, '1, '1, '1, '1, 0, 0));
    send_pulse(mk(0, '1, '1, '1, '1, 3, 0));
    send_pulse(mk(0, '1, '1, '1, '1, 0, 1));

    regs[CFG_BEAM_CODE]    = 31;
    regs[CFG_AVG_TARGET]   = 0;
    regs[CFG_TOTAL_TARGET] = 3;
    regs[CFG_MEAS_LIMIT]   = 0;
    regs[CFG_MASKS2]       = {32'hFFFF_FFFF, 32'h0000_0000};
    regs[CFG_MASKS3]       = {32'h0000_0000, 32'hFFFF_FFFF};
    regs[CFG_MASKS4]       = {32'h8000_0001, 32'h7FFF_FFFE};
    regs[CFG_MASKS5]       = '0;
    apply_config();

    send_pulse(mk(31, '1, '0, 32'h8000_0001, '1, 0, 0));
    send_pulse(mk(31, 32'hFFFF_FFFE, '0, 32'h8000_0001, '1, 0, 0));
    send_pulse(mk(31, '1, 32'h0000_0001, 32'h8000_0001, '1, 0, 0));
    send_pulse(mk(31, '1, '0, 32'h8000_0003, '1, 0, 0));
    send_pulse(mk(31, '1, '0, 32'h8000_0000, '1, 0, 0));
    send_pulse(mk(30, '1, '0, 32'h8000_0001, '1, 0, 0));
    send_pulse(mk(31, '1, '0, 32'h8000_0001, '1, 1, 0));
    send_pulse(mk(31, '1, '0, 32'h8000_0001, '0, 0, 0));
    send_pulse(mk(31, '1, '0, 32'h8000_0001, '1, 0, 0));
    // target reached: delay counts up, then run done, then holds at saturation
    send_pulse(mk(31, '1, '0, 32'h8000_0001, '1, 0, 0));
    send_pulse(mk(31, '1, '0, 32'h8000_0001, '1, 3, 0));
    send_pulse(mk(31, '1, '0, 32'h8000_0001, '1, 2, 0));
    send_pulse(mk(31, '1, '0, 32'h8000_0001, '1, 0, 0));
    send_pulse(mk(31, '1, '0, 32'h8000_0001, '1, 0, 0));
    send_pulse(mk(31, '1, '0, 32'h8000_0001, '1, 0, 1));
    send_pulse(mk(31, '1, '0, 32'h8000_0001, '1, 0, 0));
  endtask

  initial begin : rx_side
    result_t got;
    int      hold;
    result_if.ready <= 1'b0;
    @(posedge rst_ni);
    @(posedge clk_i);
    forever begin
      if (hold_req) begin
        hold     = LONG_HOLD;
        hold_req = 1'b0;
      end else begin
        hold = draw_gap(rx_steady);
      end
      if (hold > 0) begin
        result_if.ready <= 1'b0;
        repeat (hold) @(posedge clk_i);
      end
      result_if.ready <= 1'b1;
      @(posedge clk_i);
      while (!result_if.valid) @(posedge clk_i);
      got.pattern_hit   = result_if.pattern_hit;
      got.step_status   = result_if.step_status;
      got.average_done  = result_if.average_done;
      got.average_count = result_if.average_count;
      got.measure_count = result_if.measure_count;
      got.finish_delay  = result_if.finish_delay;
      got.run_done      = result_if.run_done;
      sb.check_result(got);
    end
  end

  initial begin : tx_side
    int n;
    int phase;
    sb          = new();
    hold_req    = 1'b0;
    pulses_sent = 0;
    rst_ni                  <= 1'b0;
    cfg_we_i                <= 1'b0;
    cfg_idx_i               <= CFG_BEAM_CODE;
    cfg_data_i              <= '0;
    pulse_if.valid          <= 1'b0;
    pulse_if.beam_code      <= '0;
    pulse_if.modifier_two   <= '0;
    pulse_if.modifier_three <= '0;
    pulse_if.modifier_four  <= '0;
    pulse_if.modifier_five  <= '0;
    pulse_if.data_severity  <= '0;
    pulse_if.clear_run      <= 1'b0;
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    run_directed();

    phase = 0;
    while (pulses_sent < RANDOM_PULSES) begin
      randomize_regs();
      if (phase == 0) begin
        regs[CFG_BEAM_CODE]    = 31;
        regs[CFG_AVG_TARGET]   = 16'hFFFF;
        regs[CFG_TOTAL_TARGET] = 32'hFFFF_FFFF;
        regs[CFG_MEAS_LIMIT]   = 17'h0FFFF;
      end else if (phase == 1) begin
        regs[CFG_BEAM_CODE]    = 0;
        regs[CFG_AVG_TARGET]   = 0;
        regs[CFG_TOTAL_TARGET] = 0;
        regs[CFG_MEAS_LIMIT]   = 0;
      end
      apply_config();
      // long sink stall while the source keeps pushing
      if (phase == 2) hold_req = 1'b1;
      n = $urandom_range(20, 60);
      repeat (n) begin
        send_pulse(make_pulse($urandom_range(0, 9) != 0));
        pulses_sent++;
      end
      phase++;
    end

    pulse_if.valid <= 1'b0;
    while (sb.pending() != 0) @(posedge clk_i);
    repeat (8) @(posedge clk_i);
    if (sb.mismatches == 0 && sb.pending() == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule
